/* sv/swmf_pkg.sv */
// Shared constants, types and controller codes for the sliding window median filter.
package swmf_pkg;

  localparam int MAX_WINDOW_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int LEN_BITS      = 5;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [LEN_BITS-1:0] LEN_RESET = 5'd5;

  // Register index field of the configuration address (byte address 4*i).
  localparam int CFG_IDX_BITS = CFG_ADDR_BITS - 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LEN = '0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_OUT
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic rd_issue;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rd_last;
    logic out_busy;
  } dp_sts_t;

endpackage

/* sv/swmf_in_if.sv */
// Input channel interface carrying one sample per item.
interface swmf_in_if #(
  parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

/* sv/swmf_out_if.sv */
// Result channel interface carrying one median per item.
interface swmf_out_if #(
  parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

/* sv/swmf_ctrl.sv */
// Controller state machine that sequences the window sweep for each item.
module swmf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  swmf_pkg::dp_sts_t sts,
  output swmf_pkg::dp_cmd_t cmd
);

  swmf_pkg::ctrl_state_t state_r;
  swmf_pkg::ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swmf_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      swmf_pkg::S_IDLE: begin
        // No item is taken while reset is held.
        in_ready   = rst_n;
        cmd.accept = in_valid && rst_n;
        if (in_valid) begin
          state_nxt = swmf_pkg::S_READ;
        end
      end
      swmf_pkg::S_READ: begin
        cmd.rd_issue = 1'b1;
        if (sts.rd_last) begin
          state_nxt = swmf_pkg::S_DRAIN;
        end
      end
      swmf_pkg::S_DRAIN: begin
        // The last entry read is being inserted into the sorted row.
        state_nxt = swmf_pkg::S_OUT;
      end
      swmf_pkg::S_OUT: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = swmf_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = swmf_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* sv/swmf_dp.sv */
// Datapath: window memory, write pointer, sorting row of cells and output register.
module swmf_dp #(
  parameter int MAX_WINDOW  = swmf_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [swmf_pkg::LEN_BITS-1:0]        window_len,
  input  logic                                 win_clr,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample,
  input  swmf_pkg::dp_cmd_t                    cmd,
  output swmf_pkg::dp_sts_t                    sts,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic signed [SAMPLE_BITS-1:0]        out_median
);

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LW = $clog2(MAX_WINDOW + 1);
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_WINDOW);
  localparam logic [LW:0]   CELL_LIM = (LW + 1)'(MAX_WINDOW);

  // Effective length: zero acts as one, values above the depth saturate.
  logic [LW-1:0] eff_len;
  logic [LW-1:0] len_m1;
  logic [LW-1:0] keep_cnt;

  always_comb begin
    if (window_len == '0) begin
      eff_len = LW'(1);
    end else if (32'(window_len) > 32'(MAX_WINDOW)) begin
      eff_len = LEN_MAX;
    end else begin
      eff_len = LW'(window_len);
    end
  end

  assign len_m1   = eff_len - LW'(1);
  assign keep_cnt = (len_m1 >> 1) + LW'(1);

  // Window memory with one valid bit per entry; an entry never written reads as zero.
  logic signed [SAMPLE_BITS-1:0] mem_r [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]         ent_vld_r;
  logic [AW-1:0]                 wr_pos_r;
  logic [AW-1:0]                 wr_pos_nxt;
  logic [LW-1:0]                 wr_pos_inc;
  logic [AW-1:0]                 rd_idx_r;
  logic signed [SAMPLE_BITS-1:0] rd_data_r;
  logic                          rd_vld_r;
  logic                          ins_vld_r;
  logic signed [SAMPLE_BITS-1:0] ins_value;

  assign wr_pos_inc = LW'(wr_pos_r) + LW'(1);
  assign wr_pos_nxt = (wr_pos_inc == eff_len) ? '0 : AW'(wr_pos_inc);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mem_r[wr_pos_r] <= in_sample;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= mem_r[rd_idx_r];
      rd_vld_r  <= ent_vld_r[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
      wr_pos_r  <= '0;
      rd_idx_r  <= '0;
      ins_vld_r <= 1'b0;
    end else begin
      ins_vld_r <= cmd.rd_issue;
      if (win_clr) begin
        ent_vld_r <= '0;
        wr_pos_r  <= '0;
      end else if (cmd.accept) begin
        ent_vld_r[wr_pos_r] <= 1'b1;
        wr_pos_r            <= wr_pos_nxt;
      end
      if (cmd.accept) begin
        rd_idx_r <= '0;
      end else if (cmd.rd_issue) begin
        rd_idx_r <= rd_idx_r + AW'(1);
      end
    end
  end

  assign ins_value   = rd_vld_r ? rd_data_r : '0;
  assign sts.rd_last = (LW'(rd_idx_r) == len_m1);

  // Sorting row. It keeps the keep_cnt smallest values seen so far in ascending
  // order, right aligned, so the largest of them (the lower median once the
  // whole window has passed) always sits in the top cell.
  logic signed [SAMPLE_BITS-1:0] row_r   [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] row_nxt [MAX_WINDOW];
  logic [LW-1:0]                 cnt_r;
  logic                          row_full;
  logic [MAX_WINDOW-1:0]         cell_vld;
  logic [MAX_WINDOW-1:0]         cell_gt;

  assign row_full = (cnt_r == keep_cnt);

  for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
    localparam logic [LW:0] IDX = (LW + 1)'(j);
    logic                          up_gt;
    logic                          up_vld;
    logic signed [SAMPLE_BITS-1:0] up_val;
    logic                          dn_gt;
    logic signed [SAMPLE_BITS-1:0] dn_val;
    logic                          ins_here;
    logic                          take_up;

    assign cell_vld[j] = ({1'b0, cnt_r} + IDX) >= CELL_LIM;
    assign cell_gt[j]  = cell_vld[j] && (row_r[j] > ins_value);

    if (j == MAX_WINDOW - 1) begin : g_top
      assign up_gt  = 1'b1;
      assign up_vld = 1'b0;
      assign up_val = '0;
    end else begin : g_mid
      assign up_gt  = cell_gt[j+1];
      assign up_vld = cell_vld[j+1];
      assign up_val = row_r[j+1];
    end

    if (j == 0) begin : g_bot
      assign dn_gt  = 1'b0;
      assign dn_val = '0;
    end else begin : g_low
      assign dn_gt  = cell_gt[j-1];
      assign dn_val = row_r[j-1];
    end

    // Filling: smaller values move down one cell, the new value lands just
    // below the first larger one. Full: larger values move up, dropping the top.
    assign ins_here = !cell_gt[j] && up_gt;
    assign take_up  = up_vld && !up_gt;

    always_comb begin
      if (!row_full) begin
        if (take_up) begin
          row_nxt[j] = up_val;
        end else if (ins_here) begin
          row_nxt[j] = ins_value;
        end else begin
          row_nxt[j] = row_r[j];
        end
      end else begin
        if (dn_gt) begin
          row_nxt[j] = dn_val;
        end else if (cell_gt[j]) begin
          row_nxt[j] = ins_value;
        end else begin
          row_nxt[j] = row_r[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ins_vld_r) begin
      for (int j = 0; j < MAX_WINDOW; j++) begin
        row_r[j] <= row_nxt[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.accept) begin
      cnt_r <= '0;
    end else if (ins_vld_r && !row_full) begin
      cnt_r <= cnt_r + LW'(1);
    end
  end

  // Output register.
  logic                          out_vld_r;
  logic signed [SAMPLE_BITS-1:0] median_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      median_r <= row_r[MAX_WINDOW-1];
    end
  end

  assign sts.out_busy = out_vld_r && !out_ready;
  assign out_valid    = out_vld_r;
  assign out_median   = median_r;

endmodule

/* sv/sliding_window_median_filter.sv */
// Sliding window median filter top level: register block, controller and datapath.
// An item is written into the window, its entries (effective length 1 to MAX_WINDOW) pass
// the single window read port to the sorting row, and after a drain step the result loads
// once the output register is free, shown from the next cycle. Only then is an item taken.
// Reset (synchronous, rst_n low): window cleared, write position zero, length register 5.
module sliding_window_median_filter #(
  parameter int MAX_WINDOW  = swmf_pkg::MAX_WINDOW_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  swmf_in_if.sink                              in_ch,
  swmf_out_if.source                           out_ch,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [swmf_pkg::CFG_ADDR_BITS-1:0]   cfg_paddr,
  input  logic [swmf_pkg::CFG_DATA_BITS-1:0]   cfg_pwdata,
  output logic [swmf_pkg::CFG_DATA_BITS-1:0]   cfg_prdata,
  output logic                                 cfg_pready
);

  // The configuration port completes every access in its access cycle.
  // Only one register exists: window_len at byte address 0. The low two
  // address bits are ignored; any other register index reads zero and
  // ignores writes.
  logic                                reg_hit;
  logic                                cfg_wr;
  logic                                win_clr;
  logic [swmf_pkg::LEN_BITS-1:0]       window_len_r;

  assign cfg_pready = 1'b1;
  assign reg_hit    = (cfg_paddr[swmf_pkg::CFG_ADDR_BITS-1:2] == swmf_pkg::REG_WINDOW_LEN);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Writing window_len also empties the window and rewinds the write position.
  assign win_clr = cfg_wr && reg_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= swmf_pkg::LEN_RESET;
    end else if (win_clr) begin
      window_len_r <= cfg_pwdata[swmf_pkg::LEN_BITS-1:0];
    end
  end

  always_comb begin
    if (reg_hit) begin
      cfg_prdata = {{(swmf_pkg::CFG_DATA_BITS - swmf_pkg::LEN_BITS){1'b0}}, window_len_r};
    end else begin
      cfg_prdata = '0;
    end
  end

  // The controller accepts an item only when idle, writes it into the window,
  // then sweeps every active entry through the sorting row, one per cycle.
  // The result waits in the output register, so the next item can be taken
  // while it is still pending downstream.
  swmf_pkg::dp_cmd_t cmd;
  swmf_pkg::dp_sts_t sts;

  swmf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swmf_dp #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (swmf_pkg::SAMPLE_BITS_DEF)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .window_len (window_len_r),
    .win_clr    (win_clr),
    .in_sample  (in_ch.sample),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_median (out_ch.median)
  );

  // An accepted item always starts its sweep in the following cycle.
  a_sweep_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> cmd.rd_issue)
    else $error("window sweep did not start after an accepted item");

  // A new result is never loaded over one that is still stalled downstream.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !cmd.load_out)
    else $error("pending result overwritten");

  // Result valid only rises right after the controller loads a result.
  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(cmd.load_out))
    else $error("result valid rose without a load");

  // Reads of the window and acceptance of an item never overlap.
  a_accept_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> !cmd.rd_issue && !cmd.load_out)
    else $error("item accepted while a sweep or load was active");

endmodule
